// File: sv/assert_macros.svh
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: sv/hrwd_pkg.sv
`default_nettype none
package hrwd_pkg;

  localparam int ActuatorCount = 2;
  localparam int WordLanes     = 2;
  localparam logic [31:0] NeutralWord = 32'h4040_0100;
  localparam logic [6:0]  FreqReset   = 7'd64;

  typedef enum logic [1:0] {
    ACT_KEEP = 2'd0,
    ACT_DEF  = 2'd1,
    ACT_SET  = 2'd2,
    ACT_ADD  = 2'd3
  } act_t;

  typedef struct packed {
    act_t       amp_act;
    act_t       frq_act;
    logic [8:0] amp_off;   // signed, two's complement
    logic [3:0] frq_off;   // signed
  } cmd_t;

  typedef struct packed {
    logic [7:0] hi_amp;
    logic [7:0] lo_amp;
    logic [6:0] hi_frq;
    logic [6:0] lo_frq;
  } band_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } peak_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_MERGE = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  function automatic cmd_t cmd_lookup(input logic [4:0] c);
    cmd_t e;
    e = '{ACT_KEEP, ACT_KEEP, 9'sd0, 4'sd0};
    unique case (c)
      5'd0:  e = '{ACT_DEF, ACT_DEF, 9'd0, 4'd0};
      5'd1:  e = '{ACT_SET, ACT_KEEP, 9'd0, 4'd0};
      5'd2:  e = '{ACT_SET, ACT_KEEP, 9'd240, 4'd0};
      5'd3:  e = '{ACT_SET, ACT_KEEP, 9'd224, 4'd0};
      5'd4:  e = '{ACT_SET, ACT_KEEP, 9'd208, 4'd0};
      5'd5:  e = '{ACT_SET, ACT_KEEP, 9'd192, 4'd0};
      5'd6:  e = '{ACT_SET, ACT_KEEP, 9'd176, 4'd0};
      5'd7:  e = '{ACT_SET, ACT_KEEP, 9'd160, 4'd0};
      5'd8:  e = '{ACT_SET, ACT_KEEP, 9'd144, 4'd0};
      5'd9:  e = '{ACT_SET, ACT_KEEP, 9'd128, 4'd0};
      5'd10: e = '{ACT_SET, ACT_KEEP, 9'd112, 4'd0};
      5'd11: e = '{ACT_SET, ACT_KEEP, 9'd96, 4'd0};
      5'd12: e = '{ACT_KEEP, ACT_SET, 9'd0, 4'd5};
      5'd13: e = '{ACT_KEEP, ACT_SET, 9'd0, 4'd5};
      5'd14: e = '{ACT_KEEP, ACT_SET, 9'd0, 4'd0};
      5'd15: e = '{ACT_KEEP, ACT_SET, 9'd0, 4'd7};
      5'd16: e = '{ACT_KEEP, ACT_SET, 9'd0, 4'd7};
      5'd17: e = '{ACT_ADD, ACT_ADD, 9'd4, 4'd1};
      5'd18: e = '{ACT_ADD, ACT_KEEP, 9'd4, 4'd0};
      5'd19: e = '{ACT_ADD, ACT_ADD, 9'd4, 4'hf};
      5'd20: e = '{ACT_ADD, ACT_ADD, 9'd1, 4'd1};
      5'd21: e = '{ACT_ADD, ACT_KEEP, 9'd1, 4'd0};
      5'd22: e = '{ACT_ADD, ACT_ADD, 9'd1, 4'hf};
      5'd23: e = '{ACT_KEEP, ACT_ADD, 9'd0, 4'd1};
      5'd24: e = '{ACT_KEEP, ACT_KEEP, 9'd0, 4'd0};
      5'd25: e = '{ACT_KEEP, ACT_ADD, 9'd0, 4'hf};
      5'd26: e = '{ACT_ADD, ACT_ADD, 9'h1ff, 4'd1};
      5'd27: e = '{ACT_ADD, ACT_KEEP, 9'h1ff, 4'd0};
      5'd28: e = '{ACT_ADD, ACT_ADD, 9'h1ff, 4'hf};
      5'd29: e = '{ACT_ADD, ACT_ADD, 9'h1fc, 4'd1};
      5'd30: e = '{ACT_ADD, ACT_KEEP, 9'h1fc, 4'd0};
      5'd31: e = '{ACT_ADD, ACT_ADD, 9'h1fc, 4'hf};
      default: e = '{ACT_KEEP, ACT_KEEP, 9'd0, 4'd0};
    endcase
    return e;
  endfunction

  // 8-bit value with clamp, 9-bit signed offset
  function automatic logic [7:0] amp_apply(input act_t a, input logic [8:0] off,
                                           input logic [7:0] cur);
    logic signed [10:0] s;
    logic [7:0] r;
    s = $signed({3'b000, cur}) + $signed({{2{off[8]}}, off});
    r = cur;
    case (a)
      ACT_KEEP: r = cur;
      ACT_DEF:  r = 8'd0;
      ACT_SET:  r = off[7:0];
      default: begin
        if (s < 0) r = 8'd0;
        else if (s > 11'sd255) r = 8'd255;
        else r = s[7:0];
      end
    endcase
    return r;
  endfunction

  function automatic logic [6:0] frq_apply(input act_t a, input logic [3:0] off,
                                           input logic [6:0] cur);
    logic signed [8:0] s;
    logic [6:0] r;
    s = $signed({2'b00, cur}) + $signed({{5{off[3]}}, off});
    r = cur;
    case (a)
      ACT_KEEP: r = cur;
      ACT_DEF:  r = FreqReset;
      ACT_SET:  r = {3'b000, off};
      default: begin
        if (s < 0) r = 7'd0;
        else if (s > 9'sd127) r = 7'd127;
        else r = s[6:0];
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] host_amp(input logic [6:0] v);
    logic [7:0] r;
    if (v == 7'd0) r = 8'd0;
    else if (v < 7'd16) r = 8'd7 + {v[4:0], 3'b000};
    else if (v < 7'd32) r = 8'd97 + {v, 1'b0};
    else r = 8'd128 + {1'b0, v};
    return r;
  endfunction

  function automatic logic [7:0] mag_lookup(input logic [7:0] i);
    logic [7:0] m [256];
    m = '{
      0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
      1, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
      2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3,
      3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 4, 4,
      4, 4, 4, 4, 4, 4, 5, 5, 5, 5, 5, 5, 5, 5, 5, 6,
      6, 6, 6, 6, 6, 6, 6, 7, 7, 7, 7, 7, 7, 7, 8, 8,
      8, 8, 8, 9, 9, 9, 9, 9, 9, 10, 10, 10, 10, 11, 11, 11,
      11, 12, 12, 12, 12, 13, 13, 13, 13, 14, 14, 14, 15, 15, 15, 16,
      16, 16, 17, 17, 17, 18, 18, 19, 19, 19, 20, 20, 21, 21, 22, 22,
      23, 23, 24, 24, 25, 25, 26, 26, 27, 27, 28, 29, 29, 30, 31, 31,
      32, 33, 33, 34, 35, 36, 36, 37, 38, 39, 40, 40, 41, 42, 43, 44,
      45, 46, 47, 48, 49, 50, 51, 52, 54, 55, 56, 57, 58, 60, 61, 62,
      64, 65, 67, 68, 70, 71, 73, 74, 76, 77, 79, 81, 83, 84, 86, 88,
      90, 92, 94, 96, 98, 100, 103, 105, 107, 110, 112, 114, 117, 119, 122, 125,
      128, 130, 133, 136, 139, 142, 145, 148, 152, 155, 158, 162, 165, 169, 173, 176,
      180, 184, 188, 192, 197, 201, 205, 210, 214, 219, 224, 229, 234, 239, 244, 250};
    return m[i];
  endfunction

endpackage
`default_nettype wire

// File: sv/hrwd_lane.sv
`default_nettype none
// one actuator: decodes its word over up to three sample steps
module hrwd_lane import hrwd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,     // begin decoding word
  input  wire logic        has_word,  // lane receives a word this item
  input  wire logic [31:0] word,
  input  wire logic [1:0]  step,      // 0 .. 2 after start
  output peak_t            peak
);

  band_t       st_r, st_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] w_r, w_nxt;
  logic        act_r, act_nxt;      // sequence still applying commands
  logic [1:0]  nsmp_r, nsmp_nxt;    // table samples to take
  logic        f2mix_r, f2mix_nxt;  // mixed host and command frame
  peak_t       pk_r, pk_nxt;

  cmd_t  hc, lc;
  band_t b;
  logic [4:0] hcode, lcode;
  logic [1:0] fc;

  assign peak = pk_r;
  assign fc   = word[31:30];

  // command codes for the current step
  always_comb begin
    hcode = 5'd0;
    lcode = 5'd0;
    if (f2mix_r) begin
      hcode = w_r[12:8];
      lcode = w_r[17:13];
    end else begin
      case (step)
        2'd0: begin hcode = w_r[24:20]; lcode = w_r[29:25]; end
        2'd1: begin hcode = w_r[14:10]; lcode = w_r[19:15]; end
        default: begin hcode = w_r[4:0]; lcode = w_r[9:5]; end
      endcase
    end
  end
  assign hc = cmd_lookup(hcode);
  assign lc = cmd_lookup(lcode);

  // decode at start, then one command pair and sample per step
  always_comb begin
    st_nxt = st_r; prev_nxt = prev_r; seen_nxt = seen_r; w_nxt = w_r;
    act_nxt = act_r; nsmp_nxt = nsmp_r; f2mix_nxt = f2mix_r; pk_nxt = pk_r;
    b = st_r;
    if (start) begin
      act_nxt = 1'b0; f2mix_nxt = 1'b0; nsmp_nxt = 2'd0;
      pk_nxt = '{lo: st_r.lo_amp, hi: st_r.hi_amp};
      w_nxt = word;
      if (has_word) begin
        pk_nxt = '{lo: 8'd0, hi: 8'd0};
        if (word == 32'd0 || word == NeutralWord) begin
          st_nxt = '{8'd0, 8'd0, FreqReset, FreqReset};
          prev_nxt = word; seen_nxt = 1'b1;
        end else if (seen_r && prev_r == word) begin
          pk_nxt = '{lo: st_r.lo_amp, hi: st_r.hi_amp};
        end else begin
          prev_nxt = word; seen_nxt = 1'b1;
          unique case (fc)
            2'd0: begin
              st_nxt.hi_amp = 8'd0;
              pk_nxt = '{lo: st_r.lo_amp, hi: 8'd0};
            end
            2'd1: begin
              if (word[19:0] == 20'd0) begin
                act_nxt = 1'b1; nsmp_nxt = 2'd1;
              end else if (word[1:0] == 2'b00) begin
                b.hi_frq = word[8:2];   b.hi_amp = host_amp(word[15:9]);
                b.lo_frq = word[22:16]; b.lo_amp = host_amp(word[29:23]);
                st_nxt = b;
                pk_nxt = '{lo: b.lo_amp, hi: b.hi_amp};
              end else if (word[1]) begin
                if (word[2]) begin
                  if (word[0]) b.hi_frq = word[29:23];
                  else b.lo_frq = word[29:23];
                end else if (word[0]) b.hi_amp = host_amp(word[29:23]);
                else b.lo_amp = host_amp(word[29:23]);
                st_nxt = b;
                pk_nxt = '{lo: b.lo_amp, hi: b.hi_amp};
              end else begin
                pk_nxt = '{lo: st_r.lo_amp, hi: st_r.hi_amp};
              end
            end
            2'd2: begin
              if (word[9:0] == 10'd0) begin
                act_nxt = 1'b1; nsmp_nxt = 2'd2;
              end else begin
                if (word[0]) begin
                  b.hi_frq = word[7:1]; b.hi_amp = host_amp(word[29:23]);
                  b.lo_amp = amp_apply(cmd_lookup(word[22:18]).amp_act,
                                       cmd_lookup(word[22:18]).amp_off, st_r.lo_amp);
                  b.lo_frq = frq_apply(cmd_lookup(word[22:18]).frq_act,
                                       cmd_lookup(word[22:18]).frq_off, st_r.lo_frq);
                end else begin
                  b.lo_frq = word[7:1]; b.lo_amp = host_amp(word[29:23]);
                  b.hi_amp = amp_apply(cmd_lookup(word[22:18]).amp_act,
                                       cmd_lookup(word[22:18]).amp_off, st_r.hi_amp);
                  b.hi_frq = frq_apply(cmd_lookup(word[22:18]).frq_act,
                                       cmd_lookup(word[22:18]).frq_off, st_r.hi_frq);
                end
                st_nxt = b;
                pk_nxt = '{lo: b.lo_amp, hi: b.hi_amp};
                act_nxt = 1'b1; nsmp_nxt = 2'd1; f2mix_nxt = 1'b1;
              end
            end
            default: begin
              act_nxt = 1'b1; nsmp_nxt = 2'd3;
            end
          endcase
        end
      end
    end else if (act_r) begin
      b.hi_amp = amp_apply(hc.amp_act, hc.amp_off, st_r.hi_amp);
      b.hi_frq = frq_apply(hc.frq_act, hc.frq_off, st_r.hi_frq);
      b.lo_amp = amp_apply(lc.amp_act, lc.amp_off, st_r.lo_amp);
      b.lo_frq = frq_apply(lc.frq_act, lc.frq_off, st_r.lo_frq);
      st_nxt = b;
      if (b.lo_amp > pk_r.lo) pk_nxt.lo = b.lo_amp;
      if (b.hi_amp > pk_r.hi) pk_nxt.hi = b.hi_amp;
      if ({1'b0, step} + 3'd1 >= {1'b0, nsmp_r}) act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '{8'd0, 8'd0, FreqReset, FreqReset};
      prev_r <= 32'd0;
      seen_r <= 1'b0;
      act_r  <= 1'b0;
      pk_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      act_r  <= act_nxt;
      pk_r   <= pk_nxt;
    end
    w_r     <= w_nxt;
    nsmp_r  <= nsmp_nxt;
    f2mix_r <= f2mix_nxt;
  end

endmodule
`default_nettype wire

// File: sv/hrwd_merge.sv
`default_nettype none
// max over lane peaks and magnitude lookup, registered
module hrwd_merge import hrwd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  load,
  input  peak_t      peaks [ActuatorCount],
  output logic [7:0] lo_mag,
  output logic [7:0] hi_mag
);

  peak_t mx;
  logic [7:0] lo_r, hi_r;

  always_comb begin
    mx = '0;
    for (int i = 0; i < ActuatorCount; i++) begin
      if (peaks[i].lo > mx.lo) mx.lo = peaks[i].lo;
      if (peaks[i].hi > mx.hi) mx.hi = peaks[i].hi;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r <= mag_lookup(mx.lo);
      hi_r <= mag_lookup(mx.hi);
    end
  end

  assign lo_mag = lo_r;
  assign hi_mag = hi_r;

endmodule
`default_nettype wire

// File: sv/haptic_rumble_word_decoder_core.sv
`default_nettype none
// Rumble word decoder. An accepted item is decoded in its accepting cycle.
// Each actuator lane then runs up to three command steps, one table command
// pair and one sample a step. A merge cycle takes the maximum peak per band
// over the lanes and maps it through the magnitude table. out_tvalid rises in
// the output state that follows the merge. The next item is taken in the cycle
// after the result has been transferred, so no new item is accepted while one
// is in flight. The result register holds its value while out_tready is low.
module haptic_rumble_word_decoder_core import hrwd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // first_word, second_word
  input  wire logic        in_tuser,   // payload_present
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // low_magnitude, high_magnitude
);

  state_t st_r, st_nxt;
  logic [1:0] step_r, step_nxt;
  logic start;
  peak_t peaks [ActuatorCount];
  logic [7:0] lo_mag, hi_mag;

  assign start = in_tvalid && in_tready;

  // next state
  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r;
    unique case (st_r)
      ST_IDLE: if (start) begin st_nxt = ST_RUN; step_nxt = 2'd0; end
      ST_RUN: begin
        if (step_r == 2'd2) st_nxt = ST_MERGE;
        else step_nxt = step_r + 2'd1;
      end
      ST_MERGE: st_nxt = ST_OUT;
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      step_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      step_r <= step_nxt;
    end
  end

  // actuator lanes
  for (genvar g = 0; g < ActuatorCount; g++) begin : g_lane
    localparam logic HasWord = (g < WordLanes);
    hrwd_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(start),
      .has_word(HasWord && in_tuser),
      .word(HasWord ? in_tdata[32*(g % WordLanes) +: 32] : 32'd0),
      .step(step_r), .peak(peaks[g])
    );
  end

  hrwd_merge u_merge (
    .clk(clk), .load(st_r == ST_MERGE), .peaks(peaks),
    .lo_mag(lo_mag), .hi_mag(hi_mag)
  );

  assign out_tdata = {hi_mag, lo_mag};

endmodule
`default_nettype wire

// File: sv/hrwd_checker.sv
`default_nettype none
`include "assert_macros.svh"
// port-level checks on the decoder handshake
module hrwd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);
  `CHK_IMPL(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready && !out_tvalid)
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_NEXT(a_release, clk, rst_n, out_tvalid && out_tready, !out_tvalid && in_tready)
endmodule

bind haptic_rumble_word_decoder_core hrwd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// File: dv/haptic_rumble_word_decoder_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module haptic_rumble_word_decoder_core_tb;
  import hrwd_pkg::*;

  // command table entry as used by the rumble predictor
  typedef struct {
    act_t amp_act;
    act_t frq_act;
    int   amp_off;
    int   frq_off;
  } rumble_cmd_t;

  typedef struct packed {
    logic [7:0] hi_mag;
    logic [7:0] lo_mag;
  } magnitude_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  haptic_rumble_word_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // predictor state per actuator
  logic [7:0]  hi_amp [2];
  logic [7:0]  lo_amp [2];
  logic [6:0]  hi_frq [2];
  logic [6:0]  lo_frq [2];
  logic [31:0] held_word [2];
  logic        last_valid [2];
  rumble_cmd_t cmd_rom [32];
  byte unsigned mag_rom [256];

  magnitude_t expected_mags [$];
  int mismatch_count;
  int result_count;
  int item_count;
  int cycle_count;
  int burst_left;
  int sat_hits;

  localparam int CycleLimit = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // constant tables of the decoding scheme
  initial begin
    int i;
    int offs [11];
    offs = '{240, 224, 208, 192, 176, 160, 144, 128, 112, 96, 0};
    cmd_rom[0] = '{ACT_DEF, ACT_DEF, 0, 0};
    cmd_rom[1] = '{ACT_SET, ACT_KEEP, 0, 0};
    for (i = 2; i <= 11; i++) cmd_rom[i] = '{ACT_SET, ACT_KEEP, offs[i - 2], 0};
    cmd_rom[12] = '{ACT_KEEP, ACT_SET, 0, 5};
    cmd_rom[13] = '{ACT_KEEP, ACT_SET, 0, 5};
    cmd_rom[14] = '{ACT_KEEP, ACT_SET, 0, 0};
    cmd_rom[15] = '{ACT_KEEP, ACT_SET, 0, 7};
    cmd_rom[16] = '{ACT_KEEP, ACT_SET, 0, 7};
    cmd_rom[17] = '{ACT_ADD, ACT_ADD, 4, 1};
    cmd_rom[18] = '{ACT_ADD, ACT_KEEP, 4, 0};
    cmd_rom[19] = '{ACT_ADD, ACT_ADD, 4, -1};
    cmd_rom[20] = '{ACT_ADD, ACT_ADD, 1, 1};
    cmd_rom[21] = '{ACT_ADD, ACT_KEEP, 1, 0};
    cmd_rom[22] = '{ACT_ADD, ACT_ADD, 1, -1};
    cmd_rom[23] = '{ACT_KEEP, ACT_ADD, 0, 1};
    cmd_rom[24] = '{ACT_KEEP, ACT_KEEP, 0, 0};
    cmd_rom[25] = '{ACT_KEEP, ACT_ADD, 0, -1};
    cmd_rom[26] = '{ACT_ADD, ACT_ADD, -1, 1};
    cmd_rom[27] = '{ACT_ADD, ACT_KEEP, -1, 0};
    cmd_rom[28] = '{ACT_ADD, ACT_ADD, -1, -1};
    cmd_rom[29] = '{ACT_ADD, ACT_ADD, -4, 1};
    cmd_rom[30] = '{ACT_ADD, ACT_KEEP, -4, 0};
    cmd_rom[31] = '{ACT_ADD, ACT_ADD, -4, -1};
    mag_rom = '{
      0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
      1, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
      2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3,
      3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 4, 4,
      4, 4, 4, 4, 4, 4, 5, 5, 5, 5, 5, 5, 5, 5, 5, 6,
      6, 6, 6, 6, 6, 6, 6, 7, 7, 7, 7, 7, 7, 7, 8, 8,
      8, 8, 8, 9, 9, 9, 9, 9, 9, 10, 10, 10, 10, 11, 11, 11,
      11, 12, 12, 12, 12, 13, 13, 13, 13, 14, 14, 14, 15, 15, 15, 16,
      16, 16, 17, 17, 17, 18, 18, 19, 19, 19, 20, 20, 21, 21, 22, 22,
      23, 23, 24, 24, 25, 25, 26, 26, 27, 27, 28, 29, 29, 30, 31, 31,
      32, 33, 33, 34, 35, 36, 36, 37, 38, 39, 40, 40, 41, 42, 43, 44,
      45, 46, 47, 48, 49, 50, 51, 52, 54, 55, 56, 57, 58, 60, 61, 62,
      64, 65, 67, 68, 70, 71, 73, 74, 76, 77, 79, 81, 83, 84, 86, 88,
      90, 92, 94, 96, 98, 100, 103, 105, 107, 110, 112, 114, 117, 119, 122, 125,
      128, 130, 133, 136, 139, 142, 145, 148, 152, 155, 158, 162, 165, 169, 173, 176,
      180, 184, 188, 192, 197, 201, 205, 210, 214, 219, 224, 229, 234, 239, 244, 250};
  end

  function automatic void clear_lane(int a);
    hi_amp[a] = 8'd0;
    lo_amp[a] = 8'd0;
    hi_frq[a] = FreqReset;
    lo_frq[a] = FreqReset;
    held_word[a] = 32'd0;
    last_valid[a] = 1'b0;
  endfunction

  function automatic int cmd_value(act_t act, int off, int cur, int dflt, int top);
    int r;
    case (act)
      ACT_KEEP: r = cur;
      ACT_DEF:  r = dflt;
      ACT_SET:  r = off & 8'hff;
      default: begin
        r = cur + off;
        if (r < 0) r = 0;
        else if (r > top) r = top;
        if (r == 0 || r == top) sat_hits++;
      end
    endcase
    return r;
  endfunction

  // apply one table command to one band of one lane
  function automatic void band_command(int a, bit high, logic [31:0] c);
    rumble_cmd_t e;
    e = cmd_rom[c[4:0]];
    if (high) begin
      hi_amp[a] = 8'(cmd_value(e.amp_act, e.amp_off, hi_amp[a], 0, 255));
      hi_frq[a] = 7'(cmd_value(e.frq_act, e.frq_off, hi_frq[a], FreqReset, 127));
    end else begin
      lo_amp[a] = 8'(cmd_value(e.amp_act, e.amp_off, lo_amp[a], 0, 255));
      lo_frq[a] = 7'(cmd_value(e.frq_act, e.frq_off, lo_frq[a], FreqReset, 127));
    end
  endfunction

  function automatic logic [7:0] host_level(logic [6:0] v);
    if (v == 0) return 8'd0;
    if (v < 16) return 8'd7 + 8'(8 * v);
    if (v < 32) return 8'd97 + 8'(2 * v);
    return 8'd128 + 8'(v);
  endfunction

  function automatic void take_peak(int a, ref logic [7:0] lo, ref logic [7:0] hi);
    if (lo_amp[a] > lo) lo = lo_amp[a];
    if (hi_amp[a] > hi) hi = hi_amp[a];
  endfunction

  function automatic void run_table(int a, logic [31:0] w, int n,
                                    ref logic [7:0] lo, ref logic [7:0] hi);
    for (int s = 0; s < n; s++) begin
      band_command(a, 1'b1, w >> (20 - 10 * s));
      band_command(a, 1'b0, w >> (25 - 10 * s));
      take_peak(a, lo, hi);
    end
  endfunction

  // decode one word for one lane, returning its peak amplitudes
  function automatic void decode_word(int a, logic [31:0] w,
                                      ref logic [7:0] lo, ref logic [7:0] hi);
    logic [6:0] v;
    lo = 8'd0;
    hi = 8'd0;
    if (w == 32'd0 || w == NeutralWord) begin
      clear_lane(a);
      held_word[a] = w;
      last_valid[a] = 1'b1;
      return;
    end
    if (last_valid[a] && held_word[a] == w) begin
      lo = lo_amp[a];
      hi = hi_amp[a];
      return;
    end
    held_word[a] = w;
    last_valid[a] = 1'b1;
    v = w[29:23];
    case (w[31:30])
      2'd0: begin
        hi_amp[a] = 8'd0;
        lo = lo_amp[a];
      end
      2'd1: begin
        if (w[19:0] == 0) run_table(a, w, 1, lo, hi);
        else if (w[1:0] == 2'b00) begin
          hi_frq[a] = w[8:2];
          hi_amp[a] = host_level(w[15:9]);
          lo_frq[a] = w[22:16];
          lo_amp[a] = host_level(v);
          take_peak(a, lo, hi);
        end else if (w[1]) begin
          if (w[2]) begin
            if (w[0]) hi_frq[a] = v;
            else lo_frq[a] = v;
          end else if (w[0]) hi_amp[a] = host_level(v);
          else lo_amp[a] = host_level(v);
          take_peak(a, lo, hi);
        end else begin
          lo = lo_amp[a];
          hi = hi_amp[a];
        end
      end
      2'd2: begin
        if (w[9:0] == 0) run_table(a, w, 2, lo, hi);
        else begin
          if (w[0]) begin
            hi_frq[a] = w[7:1];
            hi_amp[a] = host_level(v);
            band_command(a, 1'b0, w >> 18);
          end else begin
            lo_frq[a] = w[7:1];
            lo_amp[a] = host_level(v);
            band_command(a, 1'b1, w >> 18);
          end
          take_peak(a, lo, hi);
          band_command(a, 1'b1, w >> 8);
          band_command(a, 1'b0, w >> 13);
          take_peak(a, lo, hi);
        end
      end
      default: run_table(a, w, 3, lo, hi);
    endcase
  endfunction

  function automatic magnitude_t predict_magnitudes(logic [63:0] words, logic present);
    logic [7:0] lo, hi, lo_pk, hi_pk;
    magnitude_t m;
    lo_pk = 8'd0;
    hi_pk = 8'd0;
    for (int a = 0; a < 2; a++) begin
      lo = lo_amp[a];
      hi = hi_amp[a];
      if (present) decode_word(a, words[32 * a +: 32], lo, hi);
      if (lo > lo_pk) lo_pk = lo;
      if (hi > hi_pk) hi_pk = hi;
    end
    m.lo_mag = mag_rom[lo_pk];
    m.hi_mag = mag_rom[hi_pk];
    return m;
  endfunction

  // send one rumble item, with bursty gaps
  task automatic send_rumble(logic [31:0] w0, logic [31:0] w1, logic present);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {w1, w0};
    in_tuser  <= present;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_mags.push_back(predict_magnitudes({w1, w0}, present));
    item_count++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_mags.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] table_word(logic [1:0] fc);
    logic [31:0] w;
    w = $urandom;
    w[31:30] = fc;
    if (fc == 2'd1) w[19:0] = '0;
    if (fc == 2'd2) w[9:0] = '0;
    return w;
  endfunction

  // random well-formed word with random content, biased toward each mode
  function automatic logic [31:0] rumble_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 11))
      0: w = ($urandom_range(0, 1) != 0) ? NeutralWord : 32'd0;
      1: w[31:30] = 2'd0;
      2: begin w[31:30] = 2'd1; w[1:0] = 2'b00; end
      3: begin w[31:30] = 2'd1; w[1] = 1'b1; end
      4: begin w[31:30] = 2'd1; w[1:0] = 2'b01; end
      5: w = table_word(2'd1);
      6: w = table_word(2'd2);
      7: w[31:30] = 2'd2;
      8, 9: w = table_word(2'd3);
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_reset_and_extremes();
    send_rumble(32'd0, 32'd0, 1'b0);
    send_rumble(32'd0, NeutralWord, 1'b1);
    send_rumble(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_rumble(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_rumble(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_rumble(32'h3fff_ffff, 32'h7fff_fffc, 1'b1);
  endtask

  task automatic test_host_modes();
    send_rumble(32'h4000_0000, 32'h4000_0001, 1'b1);
    send_rumble(32'h7fff_fffe, 32'h7fff_fffb, 1'b1);
    send_rumble(32'h4080_0002, 32'h4780_0003, 1'b1);
    send_rumble(32'h4780_0007, 32'h4800_0006, 1'b1);
    send_rumble(32'h4000_0005, 32'h4000_0009, 1'b1);
    send_rumble(32'h8fff_ffff, 32'hbfff_fffe, 1'b1);
    send_rumble(32'h8000_0001, 32'h80ff_fc01, 1'b1);
  endtask

  task automatic test_table_commands();
    send_rumble(32'h4010_0000, 32'h41f0_0000, 1'b1);
    send_rumble(32'h8421_0400, 32'hbdef_7c00, 1'b1);
    send_rumble(32'hc000_0000, 32'hffff_ffff, 1'b1);
    send_rumble(32'hc631_8c63, 32'hc842_1084, 1'b1);
    send_rumble(32'hc631_8c64, 32'hfbde_f7bd, 1'b1);
    for (int c = 0; c < 32; c += 4)
      send_rumble({2'b11, 5'(c), 5'(c + 1), 5'(c + 2), 5'(c + 3), 10'h2a5},
                  {2'b11, 5'(31 - c), 5'(c), 5'(30 - c), 5'(c), 10'h15a}, 1'b1);
  endtask

  task automatic test_random_traffic(int n);
    logic [31:0] w0, w1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: begin w0 = $urandom; w1 = $urandom; end
        1: begin w0 = held_word[0]; w1 = held_word[1]; end
        default: begin w0 = rumble_word(); w1 = rumble_word(); end
      endcase
      send_rumble(w0, w1, $urandom_range(0, 9) != 0);
      if (i == n / 2) drain_results();
    end
  endtask

  // receiver stall pattern: random ready, mostly high, broken by occasional long ready runs
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 40) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: out_tready <= 1'b0;
          1: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= 1'b1;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    magnitude_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      result_count++;
      if (expected_mags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = expected_mags.pop_front();
        if (got.lo_mag !== want.lo_mag || got.hi_mag !== want.hi_mag) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: lo exp %0d got %0d, hi exp %0d got %0d",
                     result_count, want.lo_mag, got.lo_mag, want.hi_mag, got.hi_mag);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    result_count = 0;
    item_count = 0;
    cycle_count = 0;
    burst_left = 0;
    sat_hits = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    rst_n = 1'b0;
    for (int a = 0; a < 2; a++) clear_lane(a);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_and_extremes();
    test_host_modes();
    test_table_commands();
    test_random_traffic(1250);
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d items and %0d transfers across all frame modes,", item_count,
             result_count);
    $display("repeats, resets and %0d clamped additions", sat_hits);
    if (mismatch_count == 0 && expected_mags.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: haptic_rumble_word_decoder_core.f
+incdir+sv
sv/hrwd_pkg.sv
sv/hrwd_lane.sv
sv/hrwd_merge.sv
sv/haptic_rumble_word_decoder_core.sv
sv/hrwd_checker.sv
dv/haptic_rumble_word_decoder_core_tb.sv
